// ----- src/tfqp_pkg.sv -----
// Shared types, widths and elaboration-time helpers for the tangent frame
// quaternion packer. No dependencies.
package tfqp_pkg;

    localparam int STORE_BITS_DEF = 16;
    localparam int LANES          = 4;
    localparam int MAG_W          = 31;
    localparam int LEN_W          = 31;
    localparam int RAD_W          = 62;
    localparam int REM_W          = 35;
    localparam int DREM_W         = 32;
    localparam int SQRT_STEPS     = 31;
    localparam int DIV_STEPS      = 31;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [LEN_W-1:0] root;
        logic [RAD_W-1:0] rad;
    } sqrt_state_t;

    typedef struct packed {
        logic [DREM_W-1:0] rem;
        logic [MAG_W-1:0]  quo;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [LANES-1:0] lane;
        logic [LEN_W-1:0]      len;
        logic [LEN_W-1:0]      nbits;
    } div_state_t;

    // Constant-only integer square root (floor).
    function automatic longint unsigned isqrt_const(input longint unsigned v);
        longint unsigned res;
        longint unsigned rem;
        longint unsigned bit_v;
        res   = 0;
        rem   = v;
        bit_v = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= res + bit_v)
            begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

endpackage

// ----- src/tfqp_sqrt_cell.sv -----
// One bit-pair step of the pipelined integer square root.
// Depends on tfqp_pkg.
module tfqp_sqrt_cell
    import tfqp_pkg::*;
#(
    parameter int TAG_W = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  sqrt_state_t      in_state,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output sqrt_state_t      out_state,
    output logic [TAG_W-1:0] out_tag
);

    logic        valid_reg;
    sqrt_state_t state_reg;
    sqrt_state_t state_next;
    logic [TAG_W-1:0] tag_reg;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    always_comb
    begin
        rem_sh = {in_state.rem[REM_W-3:0], in_state.rad[RAD_W-1:RAD_W-2]};
        trial  = {{(REM_W-LEN_W-2){1'b0}}, in_state.root, 2'b01};
        state_next.rad = {in_state.rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            state_next.rem  = rem_sh - trial;
            state_next.root = {in_state.root[LEN_W-2:0], 1'b1};
        end
        else
        begin
            state_next.rem  = rem_sh;
            state_next.root = {in_state.root[LEN_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
            tag_reg   <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_tag   = tag_reg;

endmodule

// ----- src/tfqp_div_cell.sv -----
// One quotient-bit step of the four-lane pipelined restoring divider.
// Depends on tfqp_pkg.
module tfqp_div_cell
    import tfqp_pkg::*;
#(
    parameter int TAG_W = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  div_state_t       in_state,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output div_state_t       out_state,
    output logic [TAG_W-1:0] out_tag
);

    logic       valid_reg;
    div_state_t state_reg;
    div_state_t state_next;
    logic [TAG_W-1:0]  tag_reg;
    logic [DREM_W:0]   dvs;
    logic [DREM_W:0]   r_sh [LANES];

    always_comb
    begin
        dvs = {1'b0, in_state.len, 1'b0};
        state_next.len   = in_state.len;
        state_next.nbits = {in_state.nbits[LEN_W-2:0], 1'b0};
        for (int i = 0; i < LANES; i++)
        begin
            r_sh[i] = {in_state.lane[i].rem, in_state.nbits[LEN_W-1]};
            if (r_sh[i] >= dvs)
            begin
                state_next.lane[i].rem = DREM_W'(r_sh[i] - dvs);
                state_next.lane[i].quo = {in_state.lane[i].quo[MAG_W-2:0], 1'b1};
            end
            else
            begin
                state_next.lane[i].rem = DREM_W'(r_sh[i]);
                state_next.lane[i].quo = {in_state.lane[i].quo[MAG_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
            tag_reg   <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_tag   = tag_reg;

endmodule

// ----- src/tangent_frame_quaternion_packer.sv -----
// Tangent frame to snorm16 quaternion packer, top level.
// Depends on tfqp_pkg, tfqp_sqrt_cell and tfqp_div_cell.
// Pipeline: 7 front stages, 31 square-root cells, 31 divider cells, 3 back
// stages and an output register. One transfer per cycle while the skid
// register is empty; all stages but the output register share one enable.
// Reset clears all valid bits; no clearing pass.
module tangent_frame_quaternion_packer
    import tfqp_pkg::*;
#(
    parameter int STORE_BITS = STORE_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z,
    // normal_x, normal_y, normal_z
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // quat_x, quat_y, quat_z, quat_w
    output logic [63:0]  m_tdata
);

    localparam longint BIAS_DEN = (longint'(1) << (STORE_BITS - 1)) - 1;
    localparam longint BIAS_Q   = ((longint'(1) << 31) + BIAS_DEN) / (2 * BIAS_DEN);
    localparam longint unsigned FACTOR_Q =
        isqrt_const((64'd1 << 60) - 64'(BIAS_Q * BIAS_Q));
    localparam logic [MAG_W-1:0] BIAS_M   = MAG_W'(BIAS_Q);
    localparam logic [MAG_W-1:0] FACTOR_M = MAG_W'(FACTOR_Q);
    localparam logic [MAG_W-1:0] ONE_M    = MAG_W'(64'd1 << 30);
    localparam logic signed [34:0] ONE_Q28 = 35'sd268435456;
    localparam int SQ_TAG_W = LANES * MAG_W + LANES + 1;
    localparam int DV_TAG_W = LANES + 1;

    logic en;

    // stage 1: cross-product partial products
    logic signed [15:0] in_t [3];
    logic signed [15:0] in_b [3];
    logic signed [15:0] in_n [3];
    logic               s1_valid_reg;
    logic signed [15:0] s1_t_reg [3];
    logic signed [15:0] s1_b_reg [3];
    logic signed [15:0] s1_n_reg [3];
    logic signed [31:0] s1_p_reg [6];

    // stage 2: cross product N x T
    logic               s2_valid_reg;
    logic signed [15:0] s2_t_reg [3];
    logic signed [15:0] s2_b_reg [3];
    logic signed [15:0] s2_n_reg [3];
    logic signed [32:0] s2_c_reg [3];

    // stage 3: diagonal sums, off-diagonal terms, handedness products
    logic               s3_valid_reg;
    logic signed [34:0] s3_f_reg [4];
    logic signed [34:0] s3_o_reg [6];
    logic signed [48:0] s3_e_reg [3];
    logic signed [34:0] tq [3];
    logic signed [34:0] nq [3];
    logic signed [34:0] cq [3];

    // stage 4: largest-diagonal selection and handedness sign
    logic               s4_valid_reg;
    logic signed [34:0] s4_q_reg [4];
    logic               s4_dn_reg;
    logic               gx;
    logic               gy;
    logic               gz;
    logic signed [34:0] q_sel [4];
    logic signed [50:0] dot_sum;

    // stage 5: floor shift and magnitude
    logic                          s5_valid_reg;
    logic [LANES-1:0][MAG_W-1:0]   s5_mag_reg;
    logic [LANES-1:0]              s5_sgn_reg;
    logic                          s5_dn_reg;
    logic signed [34:0]            q_sh [4];
    logic signed [34:0]            q_abs [4];

    // stage 6: squares
    logic                          s6_valid_reg;
    logic [LANES-1:0][MAG_W-1:0]   s6_mag_reg;
    logic [LANES-1:0]              s6_sgn_reg;
    logic                          s6_dn_reg;
    logic [RAD_W-1:0]              s6_sq_reg [4];

    // stage 7: radicand, head of the square-root chain
    logic                s7_valid_reg;
    sqrt_state_t         s7_state_reg;
    logic [SQ_TAG_W-1:0] s7_tag_reg;

    logic                sq_valid [SQRT_STEPS+1];
    sqrt_state_t         sq_state [SQRT_STEPS+1];
    logic [SQ_TAG_W-1:0] sq_tag   [SQRT_STEPS+1];

    logic                dv_valid [DIV_STEPS+1];
    div_state_t          dv_state [DIV_STEPS+1];
    logic [DV_TAG_W-1:0] dv_tag   [DIV_STEPS+1];
    div_state_t          dv_head;

    logic [LANES-1:0][MAG_W-1:0] sq_mag;
    logic [LANES-1:0]            sq_sgn;
    logic                        sq_dn;

    // back stages
    logic             pa_valid_reg;
    logic             pa_low_reg;
    logic [MAG_W-1:0] pa_mag_reg [4];
    logic [61:0]      pa_prod_reg [4];
    logic             pa_sgn_reg [4];
    logic             flip0;
    logic [LANES-1:0] dv_sgn;
    logic             dv_dn;

    logic             pb_valid_reg;
    logic [45:0]      pb_prod_reg [4];
    logic             pb_sgn_reg [4];
    logic [MAG_W-1:0] mag_sc [4];
    logic [61:0]      rnd_sc [4];

    logic             pc_valid_reg;
    logic [15:0]      pc_q_reg [4];
    logic [45:0]      rnd_pk [4];
    logic [15:0]      val_pk [4];

    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic [63:0]      out_data_reg;
    logic [63:0]      skid_data_reg;
    logic [63:0]      pc_data;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_t[i] = s_tdata[16*i +: 16];
            in_b[i] = s_tdata[48 + 16*i +: 16];
            in_n[i] = s_tdata[96 + 16*i +: 16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            pa_valid_reg <= 1'b0;
            pb_valid_reg <= 1'b0;
            pc_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            pa_valid_reg <= dv_valid[DIV_STEPS];
            pb_valid_reg <= pa_valid_reg;
            pc_valid_reg <= pb_valid_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tq[i] = 35'(s2_t_reg[i]) <<< 14;
            nq[i] = 35'(s2_n_reg[i]) <<< 14;
            cq[i] = 35'(s2_c_reg[i]);
        end

        gx = s3_f_reg[1] > s3_f_reg[0];
        gy = (s3_f_reg[2] > s3_f_reg[0]) && (s3_f_reg[2] > s3_f_reg[1]);
        gz = (s3_f_reg[3] > s3_f_reg[0]) && (s3_f_reg[3] > s3_f_reg[1])
             && (s3_f_reg[3] > s3_f_reg[2]);
        if (gz)
        begin
            q_sel[0] = s3_o_reg[2];
            q_sel[1] = s3_o_reg[4];
            q_sel[2] = s3_o_reg[5];
            q_sel[3] = s3_f_reg[3] + ONE_Q28;
        end
        else if (gy)
        begin
            q_sel[0] = s3_o_reg[1];
            q_sel[1] = s3_o_reg[3];
            q_sel[2] = s3_f_reg[2] + ONE_Q28;
            q_sel[3] = s3_o_reg[5];
        end
        else if (gx)
        begin
            q_sel[0] = s3_o_reg[0];
            q_sel[1] = s3_f_reg[1] + ONE_Q28;
            q_sel[2] = s3_o_reg[3];
            q_sel[3] = s3_o_reg[4];
        end
        else
        begin
            q_sel[0] = s3_f_reg[0] + ONE_Q28;
            q_sel[1] = s3_o_reg[0];
            q_sel[2] = s3_o_reg[1];
            q_sel[3] = s3_o_reg[2];
        end
        dot_sum = 51'(s3_e_reg[0]) + 51'(s3_e_reg[1]) + 51'(s3_e_reg[2]);

        for (int i = 0; i < LANES; i++)
        begin
            q_sh[i]  = s4_q_reg[i] >>> 2;
            q_abs[i] = q_sh[i][34] ? -q_sh[i] : q_sh[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_p_reg[0] <= in_n[1] * in_t[2];
            s1_p_reg[1] <= in_n[2] * in_t[1];
            s1_p_reg[2] <= in_n[2] * in_t[0];
            s1_p_reg[3] <= in_n[0] * in_t[2];
            s1_p_reg[4] <= in_n[0] * in_t[1];
            s1_p_reg[5] <= in_n[1] * in_t[0];
            for (int i = 0; i < 3; i++)
            begin
                s1_t_reg[i] <= in_t[i];
                s1_b_reg[i] <= in_b[i];
                s1_n_reg[i] <= in_n[i];
                s2_t_reg[i] <= s1_t_reg[i];
                s2_b_reg[i] <= s1_b_reg[i];
                s2_n_reg[i] <= s1_n_reg[i];
                s2_c_reg[i] <= 33'(s1_p_reg[2*i]) - 33'(s1_p_reg[2*i+1]);
                s3_e_reg[i] <= 49'(s2_c_reg[i]) * 49'(s2_b_reg[i]);
            end

            s3_f_reg[0] <= tq[0] + cq[1] + nq[2];
            s3_f_reg[1] <= tq[0] - cq[1] - nq[2];
            s3_f_reg[2] <= cq[1] - tq[0] - nq[2];
            s3_f_reg[3] <= nq[2] - tq[0] - cq[1];
            s3_o_reg[0] <= cq[2] - nq[1];
            s3_o_reg[1] <= nq[0] - tq[2];
            s3_o_reg[2] <= tq[1] - cq[0];
            s3_o_reg[3] <= tq[1] + cq[0];
            s3_o_reg[4] <= nq[0] + tq[2];
            s3_o_reg[5] <= cq[2] + nq[1];

            for (int i = 0; i < LANES; i++)
            begin
                s4_q_reg[i]   <= q_sel[i];
                s5_mag_reg[i] <= q_abs[i][MAG_W-1:0];
                s5_sgn_reg[i] <= q_sh[i][34];
                s6_mag_reg[i] <= s5_mag_reg[i];
                s6_sgn_reg[i] <= s5_sgn_reg[i];
                s6_sq_reg[i]  <= s5_mag_reg[i] * s5_mag_reg[i];
            end
            s4_dn_reg <= dot_sum > 51'sd0;
            s5_dn_reg <= s4_dn_reg;
            s6_dn_reg <= s5_dn_reg;

            s7_state_reg.rem  <= '0;
            s7_state_reg.root <= '0;
            s7_state_reg.rad  <= s6_sq_reg[0] + s6_sq_reg[1] + s6_sq_reg[2] + s6_sq_reg[3];
            s7_tag_reg        <= {s6_dn_reg, s6_sgn_reg, s6_mag_reg};
        end
    end

    assign sq_valid[0] = s7_valid_reg;
    assign sq_state[0] = s7_state_reg;
    assign sq_tag[0]   = s7_tag_reg;

    genvar gi;
    generate
        for (gi = 0; gi < SQRT_STEPS; gi++)
        begin : g_sqrt
            tfqp_sqrt_cell #(
                .TAG_W (SQ_TAG_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (sq_valid[gi]),
                .in_state  (sq_state[gi]),
                .in_tag    (sq_tag[gi]),
                .out_valid (sq_valid[gi+1]),
                .out_state (sq_state[gi+1]),
                .out_tag   (sq_tag[gi+1])
            );
        end
    endgenerate

    assign {sq_dn, sq_sgn, sq_mag} = sq_tag[SQRT_STEPS];

    always_comb
    begin
        dv_head.len   = sq_state[SQRT_STEPS].root;
        dv_head.nbits = sq_state[SQRT_STEPS].root;
        for (int i = 0; i < LANES; i++)
        begin
            dv_head.lane[i].rem = {1'b0, sq_mag[i]};
            dv_head.lane[i].quo = '0;
        end
    end
    assign dv_state[0] = dv_head;
    assign dv_valid[0] = sq_valid[SQRT_STEPS];
    assign dv_tag[0]   = {sq_dn, sq_sgn};

    generate
        for (gi = 0; gi < DIV_STEPS; gi++)
        begin : g_div
            tfqp_div_cell #(
                .TAG_W (DV_TAG_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (dv_valid[gi]),
                .in_state  (dv_state[gi]),
                .in_tag    (dv_tag[gi]),
                .out_valid (dv_valid[gi+1]),
                .out_state (dv_state[gi+1]),
                .out_tag   (dv_tag[gi+1])
            );
        end
    endgenerate

    assign {dv_dn, dv_sgn} = dv_tag[DIV_STEPS];

    always_comb
    begin
        flip0 = dv_sgn[0] && (dv_state[DIV_STEPS].lane[0].quo != '0);
        for (int i = 0; i < LANES; i++)
        begin
            rnd_sc[i] = pa_prod_reg[i] + 62'(64'd1 << 29);
            if (pa_low_reg && (i != 0))
                mag_sc[i] = MAG_W'(rnd_sc[i] >> 30);
            else
                mag_sc[i] = pa_mag_reg[i];
            if (mag_sc[i] > ONE_M)
                mag_sc[i] = ONE_M;
            rnd_pk[i] = pb_prod_reg[i] + 46'(64'd1 << 29);
            val_pk[i] = 16'(rnd_pk[i] >> 30);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_low_reg    <= dv_state[DIV_STEPS].lane[0].quo < BIAS_M;
            pa_mag_reg[0] <= (dv_state[DIV_STEPS].lane[0].quo < BIAS_M)
                             ? BIAS_M : dv_state[DIV_STEPS].lane[0].quo;
            pa_prod_reg[0] <= '0;
            pa_sgn_reg[0]  <= dv_dn;
            for (int i = 1; i < LANES; i++)
            begin
                pa_mag_reg[i]  <= dv_state[DIV_STEPS].lane[i].quo;
                pa_prod_reg[i] <= dv_state[DIV_STEPS].lane[i].quo * FACTOR_M;
                pa_sgn_reg[i]  <= dv_sgn[i] ^ flip0 ^ dv_dn;
            end
            for (int i = 0; i < LANES; i++)
            begin
                pb_prod_reg[i] <= mag_sc[i] * 15'd32767;
                pb_sgn_reg[i]  <= pa_sgn_reg[i];
                pc_q_reg[i]    <= pb_sgn_reg[i] ? -val_pk[i] : val_pk[i];
            end
        end
    end

    assign pc_data = {pc_q_reg[0], pc_q_reg[3], pc_q_reg[2], pc_q_reg[1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg  <= skid_valid_reg || (en && pc_valid_reg);
            skid_valid_reg <= 1'b0;
        end
        else if (en && pc_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
            out_data_reg <= skid_valid_reg ? skid_data_reg : pc_data;
        else if (en && pc_valid_reg)
            skid_data_reg <= pc_data;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- dv/tfqp_checker.sv -----
// Checker for the tangent frame quaternion packer: watches both stream channels,
// computes the expected snorm16 quaternion per vertex and compares in order.
// Depends on no other file.
module tfqp_checker
#(
    parameter int STORE_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE_Q30 = 64'sd1 << 30;

    logic [63:0] quat_q[$];

    function automatic longint sq16(input logic [15:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint floor_quarter(input longint v);
        return v >>> 2;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v)
            bit_v = bit_v >> 2;
        while (bit_v != 0)
        begin
            if (v >= res + bit_v)
            begin
                v = v - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic [15:0] to_snorm16(input longint v);
        longint c;
        c = v;
        if (c > ONE_Q30)
            c = ONE_Q30;
        if (c < -ONE_Q30)
            c = -ONE_Q30;
        return 16'(round_div(c * 32767, ONE_Q30));
    endfunction

    function automatic logic [63:0] frame_to_quat(input logic [143:0] d);
        longint tx, ty, tz, bx, by, bz, nx, ny, nz;
        longint t0, t1, t2, n0, n1, n2, c0, c1, c2;
        longint fw, fx, fy, fz, a, b, c, dd, e, f, big, bias, factor, dot;
        longint q[4];
        longint unsigned sum, len;
        int sel;
        tx = sq16(d[15:0]);    ty = sq16(d[31:16]);   tz = sq16(d[47:32]);
        bx = sq16(d[63:48]);   by = sq16(d[79:64]);   bz = sq16(d[95:80]);
        nx = sq16(d[111:96]);  ny = sq16(d[127:112]); nz = sq16(d[143:128]);
        t0 = tx * 16384; t1 = ty * 16384; t2 = tz * 16384;
        n0 = nx * 16384; n1 = ny * 16384; n2 = nz * 16384;
        c0 = ny * tz - nz * ty;
        c1 = nz * tx - nx * tz;
        c2 = nx * ty - ny * tx;
        fw = t0 + c1 + n2; fx = t0 - c1 - n2;
        fy = c1 - t0 - n2; fz = n2 - t0 - c1;
        a = c2 - n1; b = n0 - t2; c = t1 - c0;
        dd = t1 + c0; e = n0 + t2; f = c2 + n1;
        sel = 0;
        big = fw;
        if (fx > big)
        begin
            big = fx; sel = 1;
        end
        if (fy > big)
        begin
            big = fy; sel = 2;
        end
        if (fz > big)
            sel = 3;
        case (sel)
            0: q = '{fw + (64'sd1 << 28), a, b, c};
            1: q = '{a, fx + (64'sd1 << 28), dd, e};
            2: q = '{b, dd, fy + (64'sd1 << 28), f};
            default: q = '{c, e, f, fz + (64'sd1 << 28)};
        endcase
        sum = 0;
        for (int i = 0; i < 4; i++)
        begin
            q[i] = floor_quarter(q[i]);
            sum += longint'(q[i] * q[i]);
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 4; i++)
            q[i] = round_div(q[i] * ONE_Q30, longint'(len));
        if (q[0] < 0)
            for (int i = 0; i < 4; i++)
                q[i] = -q[i];
        bias = round_div(ONE_Q30, (64'sd1 << (STORE_BITS - 1)) - 1);
        if (q[0] < bias)
        begin
            factor = longint'(int_sqrt((64'd1 << 60) - longint'(bias * bias)));
            q[0] = bias;
            for (int i = 1; i < 4; i++)
                q[i] = round_div(q[i] * factor, ONE_Q30);
        end
        dot = -(c0 * bx + c1 * by + c2 * bz);
        if (dot < 0)
            for (int i = 0; i < 4; i++)
                q[i] = -q[i];
        return {to_snorm16(q[0]), to_snorm16(q[3]), to_snorm16(q[2]), to_snorm16(q[1])};
    endfunction

    initial fail_count = 0;
    assign pending = quat_q.size();

    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                quat_q.push_back(frame_to_quat(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (quat_q.size() == 0)
                begin
                    $display("%0t: unexpected transfer, expected none, actual %h",
                             $time, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = quat_q.pop_front();
                    for (int k = 0; k < 4; k++)
                        if (want[16*k +: 16] != m_tdata[16*k +: 16])
                        begin
                            $display("%0t: quat lane %0d (x,y,z,w) expected %h actual %h",
                                     $time, k, want[16*k +: 16], m_tdata[16*k +: 16]);
                            fail_count++;
                        end
                end
            end
        end
    end
endmodule

// ----- dv/tb.sv -----
// Testbench top for the tangent frame quaternion packer: drives vertex frames
// with random idling and back-pressure and gives the verdict.
// Depends on tfqp_pkg, tangent_frame_quaternion_packer and tfqp_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 73;
    localparam int LIMIT   = 200000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    int           fail_count;
    int           pending;
    int           cycles;
    bit           no_idle;
    bit           hold_off;

    tangent_frame_quaternion_packer dut
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    tfqp_checker chk
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver: random stalls, long hold-off when asked
    initial
    begin
        m_tready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                m_tready <= 0;
            else
                m_tready <= no_idle || ($urandom_range(99) >= 10);
        end
    end

    function automatic logic [15:0] pick_comp();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'h4000;
            4: return 16'hc000;
            default: return 16'($urandom);
        endcase
    endfunction

    // roughly orthonormal frame from signed permutation, plus small noise
    function automatic logic [143:0] unit_frame(input bit left);
        int p;
        int sgn[3];
        logic [15:0] v[9];
        for (int i = 0; i < 9; i++)
            v[i] = 16'($signed($urandom_range(64)) - 32);
        p = $urandom_range(2);
        for (int i = 0; i < 3; i++)
            sgn[i] = $urandom_range(1) ? 16384 : -16384;
        v[p]               = v[p] + 16'(sgn[0]);
        v[6 + (p + 1) % 3] = v[6 + (p + 1) % 3] + 16'(sgn[1]);
        v[3 + (p + 2) % 3] = v[3 + (p + 2) % 3] + 16'(left ? -sgn[2] : sgn[2]);
        return {v[8], v[7], v[6], v[5], v[4], v[3], v[2], v[1], v[0]};
    endfunction

    task automatic send(input logic [143:0] d);
        s_tdata  <= d;
        s_tvalid <= 1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        if (!no_idle && $urandom_range(99) < 10)
        begin
            s_tvalid <= 0;
            repeat (1 + $urandom_range(1)) @(negedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [143:0] d;
        rst_n    = 0;
        s_tvalid = 0;
        s_tdata  = '0;
        no_idle  = 0;
        hold_off = 0;
        repeat (4) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        send('0);
        send({9{16'h8000}});
        send({9{16'h7fff}});
        send({9{16'hffff}});
        send({16'h4000, 48'h0, 16'h4000, 48'h0, 16'h4000});
        send({16'h4000, 32'h0, 16'h0, 16'hc000, 16'h0, 32'h0, 16'h4000});
        send({16'hc000, 64'h0, 16'h4000, 16'h0, 16'h4000, 16'h0});
        send({16'h0, 16'h4000, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0, 16'h4000});
        send({16'h4000, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h0});
        send({16'h0, 16'h0, 16'hc000, 16'h0, 16'h0, 16'h4000, 16'h4000, 16'h0, 16'h0});
        send({16'h0, 16'hc000, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h4000, 16'h0, 16'h0});
        send({16'h2d41, 16'h2d41, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h4000, 16'h0, 16'h0});
        for (int i = 0; i < 8; i++)
            send(unit_frame(i[0]));
        drain();

        // long receiver hold-off while the sender keeps offering
        hold_off = 1;
        fork
            begin
                repeat (300) @(negedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 120; i++)
                send(unit_frame($urandom_range(1)));
        join
        drain();

        for (int i = 0; i < 700; i++)
        begin
            no_idle = (i >= 300 && i < 420);
            if ($urandom_range(99) < 75)
                d = unit_frame($urandom_range(1));
            else
                for (int k = 0; k < 9; k++)
                    d[16*k +: 16] = pick_comp();
            send(d);
        end
        no_idle = 0;
        drain();
        repeat (LATENCY + 10) @(negedge clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
